// ----- sv/hbcs_pkg.sv -----
// Shared types, constants and register codes for the HSV blob centroid steering block.
package hbcs_pkg;

  // Pixel channels and configuration port.
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned SIZE_W     = 12;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  // Result fields.
  localparam int unsigned HIT_W  = 23;
  localparam int unsigned CENT_W = 11;
  localparam int unsigned VEL_W  = 16;
  localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

  // Steering arithmetic: the offset is clipped to DIFF_W bits before the
  // multiply, which is wide enough that any clipped offset saturates anyway.
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned DIFF_W = 24;
  localparam int unsigned PROD_W = DIFF_W + GAIN_W + 1;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_WIDTH_DEF        = 2048;
  localparam int unsigned MAX_HEIGHT_DEF       = 2048;
  localparam int unsigned FORWARD_GAIN_Q16_DEF = 131;
  localparam int unsigned TURN_GAIN_Q16_DEF    = 197;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_HIGH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_LOW      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_LOW      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_HIGH     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd7;

  // Configuration register reset values.
  localparam logic [PIX_W-1:0]  HUE_LOW_RST      = 8'd10;
  localparam logic [PIX_W-1:0]  HUE_HIGH_RST     = 8'd40;
  localparam logic [PIX_W-1:0]  SAT_LOW_RST      = 8'd90;
  localparam logic [PIX_W-1:0]  SAT_HIGH_RST     = 8'd255;
  localparam logic [PIX_W-1:0]  VAL_LOW_RST      = 8'd1;
  localparam logic [PIX_W-1:0]  VAL_HIGH_RST     = 8'd255;
  localparam logic [SIZE_W-1:0] FRAME_WIDTH_RST  = 12'd960;
  localparam logic [SIZE_W-1:0] FRAME_HEIGHT_RST = 12'd540;

  // Configuration register set as seen by the pixel datapath.
  typedef struct packed {
    logic [PIX_W-1:0]  hue_low;
    logic [PIX_W-1:0]  hue_high;
    logic [PIX_W-1:0]  sat_low;
    logic [PIX_W-1:0]  sat_high;
    logic [PIX_W-1:0]  val_low;
    logic [PIX_W-1:0]  val_high;
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
  } cfg_t;

endpackage

// ----- sv/hbcs_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
module hbcs_div import hbcs_pkg::*; #(
  parameter int unsigned DW = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DW-1:0]    dividend_i,
  input  logic [HIT_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DW-1:0]    quotient_o
);

  localparam int unsigned CNT_W = (DW > 1) ? $clog2(DW) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DW - 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [HIT_W-1:0] div_q;
  logic [HIT_W-1:0] rem_q;
  logic [DW-1:0]    quo_q;

  logic [HIT_W:0]   trial;
  logic             fits;
  logic [HIT_W-1:0] rem_d;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    fits  = (trial >= {1'b0, div_q});
    rem_d = fits ? HIT_W'(trial - {1'b0, div_q}) : trial[HIT_W-1:0];
  end

  // The dividend is shifted out of the quotient register as quotient bits enter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      div_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        div_q  <= divisor_i;
        rem_q  <= '0;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= rem_d;
        quo_q <= {quo_q[DW-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- sv/hbcs_accum.sv -----
// Pixel classifier, raster position tracking and per-frame match accumulators.
module hbcs_accum import hbcs_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int unsigned XW  = $clog2(MAX_WIDTH),
  localparam int unsigned YW  = $clog2(MAX_HEIGHT),
  localparam int unsigned WEW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HEW = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned SXW = XW + XW + YW,
  localparam int unsigned SYW = XW + YW + YW
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             pix_fire_i,
  input  logic [PIX_W-1:0] hue_i,
  input  logic [PIX_W-1:0] saturation_i,
  input  logic [PIX_W-1:0] brightness_i,
  input  logic             clear_i,
  output logic             frame_end_o,
  output logic [WEW-2:0]   half_w_o,
  output logic [HEW-2:0]   half_h_o,
  output logic [SXW-1:0]   col_sum_o,
  output logic [SYW-1:0]   row_sum_o,
  output logic [HIT_W-1:0] hit_o
);

  localparam int unsigned CWW = (WEW > SIZE_W) ? WEW : SIZE_W;
  localparam int unsigned CHW = (HEW > SIZE_W) ? HEW : SIZE_W;

  logic [XW-1:0]    col_q;
  logic [YW-1:0]    row_q;
  logic [SXW-1:0]   col_sum_q;
  logic [SYW-1:0]   row_sum_q;
  logic [HIT_W-1:0] hit_q;

  logic [CWW-1:0] w_raw;
  logic [CHW-1:0] h_raw;
  logic [WEW-1:0] w_eff;
  logic [HEW-1:0] h_eff;
  logic           match;
  logic           row_end;
  logic           frame_end;

  // Effective frame size: zero acts as one, oversize clips to the maximum.
  always_comb begin
    w_raw = CWW'(cfg_i.frame_width);
    h_raw = CHW'(cfg_i.frame_height);
    if (w_raw == '0) begin
      w_eff = WEW'(1);
    end else if (w_raw > CWW'(MAX_WIDTH)) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(w_raw);
    end
    if (h_raw == '0) begin
      h_eff = HEW'(1);
    end else if (h_raw > CHW'(MAX_HEIGHT)) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = HEW'(h_raw);
    end
  end

  // Inclusive window test on all three channels.
  assign match = (hue_i >= cfg_i.hue_low) && (hue_i <= cfg_i.hue_high) &&
                 (saturation_i >= cfg_i.sat_low) && (saturation_i <= cfg_i.sat_high) &&
                 (brightness_i >= cfg_i.val_low) && (brightness_i <= cfg_i.val_high);

  // A position at or past the last column or row ends the row or the frame.
  assign row_end   = (WEW'(col_q) >= (w_eff - 1'b1));
  assign frame_end = row_end && (HEW'(row_q) >= (h_eff - 1'b1));

  // Position counters and accumulators.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      col_sum_q <= '0;
      row_sum_q <= '0;
      hit_q     <= '0;
    end else if (clear_i) begin
      col_sum_q <= '0;
      row_sum_q <= '0;
      hit_q     <= '0;
    end else if (pix_fire_i) begin
      if (match) begin
        col_sum_q <= col_sum_q + SXW'(col_q);
        row_sum_q <= row_sum_q + SYW'(row_q);
        if (hit_q != HIT_MAX) begin
          hit_q <= hit_q + 1'b1;
        end
      end
      if (frame_end) begin
        col_q <= '0;
        row_q <= '0;
      end else if (row_end) begin
        col_q <= '0;
        row_q <= row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  assign frame_end_o = frame_end;
  assign half_w_o    = w_eff[WEW-1:1];
  assign half_h_o    = h_eff[HEW-1:1];
  assign col_sum_o   = col_sum_q;
  assign row_sum_o   = row_sum_q;
  assign hit_o       = hit_q;

endmodule

// ----- sv/hsv_blob_centroid_steering.sv -----
// Top level: configuration registers, end-of-frame sequencer, steering math and result register.
//
// Pixels enter on the input channel (in_valid_i / in_stall_o) in raster order,
// one transfer per cycle while the block is accumulating. Each pixel is tested
// against six inclusive HSV bounds, and the block tracks column and row itself
// from the frame_width and frame_height registers.
// On the transfer of the last pixel of a frame the block holds in_stall_o high
// while a shared restoring divider forms the x and then the y centroid, one
// quotient bit per cycle, and one shared multiplier forms both velocities.
// The result then appears on the output channel. The divider width DW is the
// accumulator width (33 at the default 2048x2048 maximum). A frame with no
// matching pixel gives an all-zero result without running the divider.
// The result sits in an output register until out_stall_i is low; pixels keep
// flowing meanwhile, and only the next frame-end pixel waits for it.
// Reset restores the register defaults, clears the position and accumulators
// and empties the output register. Configuration writes go through cfg_we_i
// and take effect at once; they are meant for times when the block is idle.
module hsv_blob_centroid_steering import hbcs_pkg::*; #(
  parameter int unsigned MAX_WIDTH        = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT       = MAX_HEIGHT_DEF,
  parameter int unsigned FORWARD_GAIN_Q16 = FORWARD_GAIN_Q16_DEF,
  parameter int unsigned TURN_GAIN_Q16    = TURN_GAIN_Q16_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // Configuration write port.
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  // Pixel channel.
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [PIX_W-1:0]        hue_i,
  input  logic [PIX_W-1:0]        saturation_i,
  input  logic [PIX_W-1:0]        brightness_i,
  // Result channel.
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    target_found_o,
  output logic [CENT_W-1:0]       centroid_x_o,
  output logic [CENT_W-1:0]       centroid_y_o,
  output logic [HIT_W-1:0]        match_count_o,
  output logic signed [VEL_W-1:0] forward_velocity_o,
  output logic signed [VEL_W-1:0] turn_velocity_o
);

  localparam int unsigned XW   = $clog2(MAX_WIDTH);
  localparam int unsigned YW   = $clog2(MAX_HEIGHT);
  localparam int unsigned WEW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HEW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned SXW  = XW + XW + YW;
  localparam int unsigned SYW  = XW + YW + YW;
  localparam int unsigned DW   = (SXW > SYW) ? SXW : SYW;
  localparam int unsigned SATW = (DW + 2 > DIFF_W) ? DW + 2 : DIFF_W + 1;

  localparam logic signed [GAIN_W:0] FWD_GAIN = {1'b0, GAIN_W'(FORWARD_GAIN_Q16)};
  localparam logic signed [GAIN_W:0] TRN_GAIN = {1'b0, GAIN_W'(TURN_GAIN_Q16)};

  localparam logic signed [SATW-1:0]   DIFF_MAX = SATW'(2 ** (DIFF_W - 1) - 1);
  localparam logic signed [SATW-1:0]   DIFF_MIN = SATW'(-(2 ** (DIFF_W - 1)));
  localparam logic signed [PROD_W-1:0] VEL_MAX  = PROD_W'(2 ** (VEL_W - 1) - 1);
  localparam logic signed [PROD_W-1:0] VEL_MIN  = PROD_W'(-(2 ** (VEL_W - 1)));

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_CHECK,
    ST_DIV_X,
    ST_DIV_Y,
    ST_STEER_F,
    ST_STEER_T,
    ST_FINISH
  } state_e;

  // Clip the centroid offset to the multiplier operand width.
  function automatic logic signed [DIFF_W-1:0] clip_diff(input logic signed [SATW-1:0] v);
    logic signed [DIFF_W-1:0] r;
    if (v > DIFF_MAX) begin
      r = DIFF_MAX[DIFF_W-1:0];
    end else if (v < DIFF_MIN) begin
      r = DIFF_MIN[DIFF_W-1:0];
    end else begin
      r = v[DIFF_W-1:0];
    end
    return r;
  endfunction

  // Floor shift from Q16 to Q12, then saturate to the velocity range.
  function automatic logic signed [VEL_W-1:0] to_vel(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    logic signed [VEL_W-1:0]  r;
    s = p >>> 4;
    if (s > VEL_MAX) begin
      r = VEL_MAX[VEL_W-1:0];
    end else if (s < VEL_MIN) begin
      r = VEL_MIN[VEL_W-1:0];
    end else begin
      r = s[VEL_W-1:0];
    end
    return r;
  endfunction

  cfg_t cfg_q;

  state_e                    state_q;
  logic [DW-1:0]             cx_q;
  logic [DW-1:0]             cy_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [VEL_W-1:0]   fwd_q;
  logic                      out_valid_q;
  logic                      found_q;
  logic [CENT_W-1:0]         cent_x_q;
  logic [CENT_W-1:0]         cent_y_q;
  logic [HIT_W-1:0]          count_q;
  logic signed [VEL_W-1:0]   fwd_out_q;
  logic signed [VEL_W-1:0]   turn_out_q;

  logic                      pix_fire;
  logic                      frame_end;
  logic [WEW-2:0]            half_w;
  logic [HEW-2:0]            half_h;
  logic [SXW-1:0]            col_sum;
  logic [SYW-1:0]            row_sum;
  logic [HIT_W-1:0]          hit;
  logic                      accum_clear;
  logic                      no_hit;

  logic                      div_start;
  logic [DW-1:0]             div_dividend;
  logic                      div_done;
  logic [DW-1:0]             div_quo;

  logic signed [SATW-1:0]    dx_wide;
  logic signed [SATW-1:0]    dy_wide;
  logic signed [DIFF_W-1:0]  mul_a;
  logic signed [GAIN_W:0]    mul_b;
  logic signed [PROD_W-1:0]  prod_d;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hue_low      <= HUE_LOW_RST;
      cfg_q.hue_high     <= HUE_HIGH_RST;
      cfg_q.sat_low      <= SAT_LOW_RST;
      cfg_q.sat_high     <= SAT_HIGH_RST;
      cfg_q.val_low      <= VAL_LOW_RST;
      cfg_q.val_high     <= VAL_HIGH_RST;
      cfg_q.frame_width  <= FRAME_WIDTH_RST;
      cfg_q.frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HUE_LOW:      cfg_q.hue_low      <= cfg_data_i[PIX_W-1:0];
        CFG_HUE_HIGH:     cfg_q.hue_high     <= cfg_data_i[PIX_W-1:0];
        CFG_SAT_LOW:      cfg_q.sat_low      <= cfg_data_i[PIX_W-1:0];
        CFG_SAT_HIGH:     cfg_q.sat_high     <= cfg_data_i[PIX_W-1:0];
        CFG_VAL_LOW:      cfg_q.val_low      <= cfg_data_i[PIX_W-1:0];
        CFG_VAL_HIGH:     cfg_q.val_high     <= cfg_data_i[PIX_W-1:0];
        CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i[SIZE_W-1:0];
        CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Pixels flow while accumulating; a frame-end pixel also waits for a free result register.
  assign in_stall_o = (state_q != ST_ACCUM) || (out_valid_q && frame_end);
  assign pix_fire   = in_valid_i && !in_stall_o;

  assign no_hit      = (hit == '0);
  assign accum_clear = ((state_q == ST_CHECK) && no_hit) || (state_q == ST_FINISH);

  hbcs_accum #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .pix_fire_i   (pix_fire),
    .hue_i        (hue_i),
    .saturation_i (saturation_i),
    .brightness_i (brightness_i),
    .clear_i      (accum_clear),
    .frame_end_o  (frame_end),
    .half_w_o     (half_w),
    .half_h_o     (half_h),
    .col_sum_o    (col_sum),
    .row_sum_o    (row_sum),
    .hit_o        (hit)
  );

  // The divider runs the column sum first, then the row sum.
  assign div_start    = ((state_q == ST_CHECK) && !no_hit) ||
                        ((state_q == ST_DIV_X) && div_done);
  assign div_dividend = (state_q == ST_CHECK) ? DW'(col_sum) : DW'(row_sum);

  hbcs_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (hit),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Offsets from frame center, and one shared multiplier for both gains.
  always_comb begin
    dx_wide = $signed(SATW'(half_w)) - $signed(SATW'(cx_q));
    dy_wide = $signed(SATW'(half_h)) - $signed(SATW'(cy_q));
    if (state_q == ST_STEER_F) begin
      mul_a = clip_diff(dy_wide);
      mul_b = FWD_GAIN;
    end else begin
      mul_a = clip_diff(dx_wide);
      mul_b = TRN_GAIN;
    end
    prod_d = mul_a * mul_b;
  end

  // End-of-frame sequencer and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      cx_q        <= '0;
      cy_q        <= '0;
      prod_q      <= '0;
      fwd_q       <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      cent_x_q    <= '0;
      cent_y_q    <= '0;
      count_q     <= '0;
      fwd_out_q   <= '0;
      turn_out_q  <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_ACCUM: begin
          if (pix_fire && frame_end) begin
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (no_hit) begin
            out_valid_q <= 1'b1;
            found_q     <= 1'b0;
            cent_x_q    <= '0;
            cent_y_q    <= '0;
            count_q     <= '0;
            fwd_out_q   <= '0;
            turn_out_q  <= '0;
            state_q     <= ST_ACCUM;
          end else begin
            state_q <= ST_DIV_X;
          end
        end
        ST_DIV_X: begin
          if (div_done) begin
            cx_q    <= div_quo;
            state_q <= ST_DIV_Y;
          end
        end
        ST_DIV_Y: begin
          if (div_done) begin
            cy_q    <= div_quo;
            state_q <= ST_STEER_F;
          end
        end
        ST_STEER_F: begin
          prod_q  <= prod_d;
          state_q <= ST_STEER_T;
        end
        ST_STEER_T: begin
          fwd_q   <= to_vel(prod_q);
          prod_q  <= prod_d;
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          out_valid_q <= 1'b1;
          found_q     <= 1'b1;
          cent_x_q    <= cx_q[CENT_W-1:0];
          cent_y_q    <= cy_q[CENT_W-1:0];
          count_q     <= hit;
          fwd_out_q   <= fwd_q;
          turn_out_q  <= to_vel(prod_q);
          state_q     <= ST_ACCUM;
        end
        default: begin
          state_q <= ST_ACCUM;
        end
      endcase
    end
  end

  assign out_valid_o        = out_valid_q;
  assign target_found_o     = found_q;
  assign centroid_x_o       = cent_x_q;
  assign centroid_y_o       = cent_y_q;
  assign match_count_o      = count_q;
  assign forward_velocity_o = fwd_out_q;
  assign turn_velocity_o    = turn_out_q;

endmodule
